// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rpi_pkg.sv =====
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared constants, operand codes and the multiply-accumulate microprogram of
// the ray / parallelogram intersection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpi_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 12;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_CAST = 1'b1;

   typedef logic [3:0] sel_type;
   typedef logic [4:0] uop_idx_type;

   // multiplicand (wide) operand codes
   localparam sel_type A_D0 = 4'd0;
   localparam sel_type A_D1 = 4'd1;
   localparam sel_type A_D2 = 4'd2;
   localparam sel_type A_W0 = 4'd3;
   localparam sel_type A_W1 = 4'd4;
   localparam sel_type A_W2 = 4'd5;
   localparam sel_type A_P0 = 4'd6;
   localparam sel_type A_P1 = 4'd7;
   localparam sel_type A_P2 = 4'd8;
   localparam sel_type A_Q0 = 4'd9;
   localparam sel_type A_Q1 = 4'd10;
   localparam sel_type A_Q2 = 4'd11;
   localparam sel_type A_NT = 4'd12;

   // multiplier (narrow) operand codes
   localparam sel_type B_E10 = 4'd0;
   localparam sel_type B_E11 = 4'd1;
   localparam sel_type B_E12 = 4'd2;
   localparam sel_type B_E20 = 4'd3;
   localparam sel_type B_E21 = 4'd4;
   localparam sel_type B_E22 = 4'd5;
   localparam sel_type B_W0  = 4'd6;
   localparam sel_type B_W1  = 4'd7;
   localparam sel_type B_W2  = 4'd8;
   localparam sel_type B_D0  = 4'd9;
   localparam sel_type B_D1  = 4'd10;
   localparam sel_type B_D2  = 4'd11;
   localparam sel_type B_LEN = 4'd12;

   // accumulator destinations
   localparam sel_type DST_P0   = 4'd0;
   localparam sel_type DST_P1   = 4'd1;
   localparam sel_type DST_P2   = 4'd2;
   localparam sel_type DST_Q0   = 4'd3;
   localparam sel_type DST_Q1   = 4'd4;
   localparam sel_type DST_Q2   = 4'd5;
   localparam sel_type DST_DET  = 4'd6;
   localparam sel_type DST_NT   = 4'd7;
   localparam sel_type DST_NU   = 4'd8;
   localparam sel_type DST_NV   = 4'd9;
   localparam sel_type DST_SQ   = 4'd10;
   localparam sel_type DST_NTL  = 4'd11;
   localparam sel_type DST_NONE = 4'd12;

   typedef struct packed {
      sel_type a_sel;
      sel_type b_sel;
      logic    clr;
      logic    neg;
      sel_type dest;
   } uop_type;

   localparam uop_idx_type UOP_FIRST   = 5'd0;
   localparam uop_idx_type UOP_SQ_LAST = 5'd26;
   localparam uop_idx_type UOP_LEN     = 5'd27;

   function automatic uop_type uop_lookup(input uop_idx_type idx);
      uop_type u;
      u = '{A_D0, B_D0, 1'b1, 1'b0, DST_NONE};
      case (idx)
         // P = D x E2
         5'd0:  u = '{A_D1, B_E22, 1'b1, 1'b0, DST_NONE};
         5'd1:  u = '{A_D2, B_E21, 1'b0, 1'b1, DST_P0};
         5'd2:  u = '{A_D2, B_E20, 1'b1, 1'b0, DST_NONE};
         5'd3:  u = '{A_D0, B_E22, 1'b0, 1'b1, DST_P1};
         5'd4:  u = '{A_D0, B_E21, 1'b1, 1'b0, DST_NONE};
         5'd5:  u = '{A_D1, B_E20, 1'b0, 1'b1, DST_P2};
         // Q = W x E1
         5'd6:  u = '{A_W1, B_E12, 1'b1, 1'b0, DST_NONE};
         5'd7:  u = '{A_W2, B_E11, 1'b0, 1'b1, DST_Q0};
         5'd8:  u = '{A_W2, B_E10, 1'b1, 1'b0, DST_NONE};
         5'd9:  u = '{A_W0, B_E12, 1'b0, 1'b1, DST_Q1};
         5'd10: u = '{A_W0, B_E11, 1'b1, 1'b0, DST_NONE};
         5'd11: u = '{A_W1, B_E10, 1'b0, 1'b1, DST_Q2};
         // det = P.E1
         5'd12: u = '{A_P0, B_E10, 1'b1, 1'b0, DST_NONE};
         5'd13: u = '{A_P1, B_E11, 1'b0, 1'b0, DST_NONE};
         5'd14: u = '{A_P2, B_E12, 1'b0, 1'b0, DST_DET};
         // nt = Q.E2
         5'd15: u = '{A_Q0, B_E20, 1'b1, 1'b0, DST_NONE};
         5'd16: u = '{A_Q1, B_E21, 1'b0, 1'b0, DST_NONE};
         5'd17: u = '{A_Q2, B_E22, 1'b0, 1'b0, DST_NT};
         // nu = P.W
         5'd18: u = '{A_P0, B_W0, 1'b1, 1'b0, DST_NONE};
         5'd19: u = '{A_P1, B_W1, 1'b0, 1'b0, DST_NONE};
         5'd20: u = '{A_P2, B_W2, 1'b0, 1'b0, DST_NU};
         // nv = Q.D
         5'd21: u = '{A_Q0, B_D0, 1'b1, 1'b0, DST_NONE};
         5'd22: u = '{A_Q1, B_D1, 1'b0, 1'b0, DST_NONE};
         5'd23: u = '{A_Q2, B_D2, 1'b0, 1'b0, DST_NV};
         // squared direction length
         5'd24: u = '{A_D0, B_D0, 1'b1, 1'b0, DST_NONE};
         5'd25: u = '{A_D1, B_D1, 1'b0, 1'b0, DST_NONE};
         5'd26: u = '{A_D2, B_D2, 1'b0, 1'b0, DST_SQ};
         // nt * length
         5'd27: u = '{A_NT, B_LEN, 1'b1, 1'b0, DST_NTL};
         default: u = '{A_D0, B_D0, 1'b1, 1'b0, DST_NONE};
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/core/rpi_req_if.sv =====
// ----------------------------------------------------------------------------
// rpi_req_if
// Request channel: corner loads and ray casts, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpi_req_if #(
   parameter int COORD_WIDTH = rpi_pkg::COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [1:0]                    corner_index;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;

   modport source (
      output valid, action, corner_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
      input  ready
   );
   modport sink (
      input  valid, action, corner_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
      output ready
   );
endinterface

// ===== rtl/core/rpi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rpi_rsp_if
// Response channel: hit flag, distance and surface coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpi_rsp_if #(
   parameter int COORD_WIDTH = rpi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rpi_pkg::FRAC_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [COORD_WIDTH-2:0] distance;
   logic [FRAC_BITS:0]     coord_u;
   logic [FRAC_BITS:0]     coord_v;

   modport source (output valid, hit, distance, coord_u, coord_v, input ready);
   modport sink (input valid, hit, distance, coord_u, coord_v, output ready);
endinterface

// ===== rtl/core/ray_parallelogram_intersect_unit.sv =====
// Ray / parallelogram intersection unit.
// req_chan carries two kinds of transfer. A load (action 0) writes corner
// v0, v1 or v2 from pos_x/y/z; the unit stays idle and gives no response.
// A load to corner index three is dropped. A cast (action 1) tests the ray
// pos + t*dir against v0 + u*(v1-v0) + v*(v2-v0), 0 <= u, v <= 1, and gives
// exactly one transfer on rsp_chan: hit, distance along the normalized
// direction (saturating) and u, v; all zero on a miss.
// Apart from the edge and offset subtractions done as a cast is taken, all
// arithmetic runs on one shared wide adder under a microsequencer: a
// bit-serial multiply-accumulate covers the cross and dot products, then come
// sign fixup, range compares, two restoring divisions, a digit-by-digit
// square root and the distance division. The bit-serial multiplier takes
// most of the time of a cast.
// req_chan.ready is high only while the unit is idle, so one item is in
// flight at a time. A finished response holds on rsp_chan until the receiver
// takes it; a stall there simply delays the next request.
// Reset (synchronous, active high) returns the sequencer to idle; corners
// read as undefined until loaded.
// ----------------------------------------------------------------------------
// ray_parallelogram_intersect_unit
// Moller-Trumbore style ray test against a stored parallelogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ray_parallelogram_intersect_unit #(
   parameter int COORD_WIDTH = rpi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rpi_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rpi_req_if.sink   req_chan,
   rpi_rsp_if.source rsp_chan
);
   import rpi_pkg::*;

   localparam int N     = COORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int EW    = N + 1;
   localparam int MB    = N + 2;
   localparam int WW    = 4 * N + 6;
   localparam int QW    = (N > F + 1) ? N : F + 1;
   localparam int CNT_W = $clog2(N + 2);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_ACC   = 4'd3;
   localparam logic [3:0] ST_NORM  = 4'd4;
   localparam logic [3:0] ST_CMP   = 4'd5;
   localparam logic [3:0] ST_DIVU  = 4'd6;
   localparam logic [3:0] ST_DIVV  = 4'd7;
   localparam logic [3:0] ST_SQRT  = 4'd8;
   localparam logic [3:0] ST_DIVD  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;

   logic signed [N-1:0]  cx_ff[3], cx_in[3];
   logic signed [N-1:0]  cy_ff[3], cy_in[3];
   logic signed [N-1:0]  cz_ff[3], cz_in[3];
   logic signed [N-1:0]  d_ff[3], d_in[3];
   logic signed [EW-1:0] w_ff[3], w_in[3];
   logic signed [EW-1:0] e1_ff[3], e1_in[3];
   logic signed [EW-1:0] e2_ff[3], e2_in[3];

   logic [WW-1:0] p_ff[3], p_in[3];
   logic [WW-1:0] q_ff[3], q_in[3];
   logic [WW-1:0] det_ff, det_in;
   logic [WW-1:0] nt_ff, nt_in;
   logic [WW-1:0] nu_ff, nu_in;
   logic [WW-1:0] nv_ff, nv_in;
   logic [WW-1:0] acc_ff, acc_in;
   logic [WW-1:0] prod_ff, prod_in;
   logic [WW-1:0] a_ff, a_in;
   logic [WW-1:0] rem_ff, rem_in;
   logic [WW-1:0] dsh_ff, dsh_in;
   logic [MB-1:0] bsh_ff, bsh_in;
   logic [N-1:0]  root_ff, root_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [F:0]    u_ff, u_in;
   logic [F:0]    v_ff, v_in;
   logic [N-2:0]  dist_ff, dist_in;
   logic          hit_ff, hit_in;
   logic          le_u_ff, le_u_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   uop_idx_type   op_ff, op_in;

   uop_type       cur_uop;
   logic [WW-1:0] a_val;
   logic [MB-1:0] b_val;
   logic [WW-1:0] add_x, add_y, add_sum;
   logic          add_inv, add_neg;
   logic [WW-1:0] sq_rem, sq_trial;
   logic          q_bit;
   logic          req_fire, rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign cur_uop  = uop_lookup(op_ff);

   // shared adder: x + y, or x - y when add_inv
   assign add_sum = add_x + (add_inv ? ~add_y : add_y) + WW'(add_inv);
   assign add_neg = add_sum[WW-1];
   assign q_bit   = !add_neg;

   assign sq_rem   = (rem_ff << 2) | WW'(dsh_ff[2*N-1 -: 2]);
   assign sq_trial = WW'({root_ff, 2'b01});

   always_comb begin
      case (cur_uop.a_sel)
         A_D0:    a_val = WW'(d_ff[0]);
         A_D1:    a_val = WW'(d_ff[1]);
         A_D2:    a_val = WW'(d_ff[2]);
         A_W0:    a_val = WW'(w_ff[0]);
         A_W1:    a_val = WW'(w_ff[1]);
         A_W2:    a_val = WW'(w_ff[2]);
         A_P0:    a_val = p_ff[0];
         A_P1:    a_val = p_ff[1];
         A_P2:    a_val = p_ff[2];
         A_Q0:    a_val = q_ff[0];
         A_Q1:    a_val = q_ff[1];
         A_Q2:    a_val = q_ff[2];
         A_NT:    a_val = nt_ff;
         default: a_val = '0;
      endcase
   end

   always_comb begin
      case (cur_uop.b_sel)
         B_E10:   b_val = MB'(e1_ff[0]);
         B_E11:   b_val = MB'(e1_ff[1]);
         B_E12:   b_val = MB'(e1_ff[2]);
         B_E20:   b_val = MB'(e2_ff[0]);
         B_E21:   b_val = MB'(e2_ff[1]);
         B_E22:   b_val = MB'(e2_ff[2]);
         B_W0:    b_val = MB'(w_ff[0]);
         B_W1:    b_val = MB'(w_ff[1]);
         B_W2:    b_val = MB'(w_ff[2]);
         B_D0:    b_val = MB'(d_ff[0]);
         B_D1:    b_val = MB'(d_ff[1]);
         B_D2:    b_val = MB'(d_ff[2]);
         B_LEN:   b_val = MB'(root_ff);
         default: b_val = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      d_in     = d_ff;
      w_in     = w_ff;
      e1_in    = e1_ff;
      e2_in    = e2_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      det_in   = det_ff;
      nt_in    = nt_ff;
      nu_in    = nu_ff;
      nv_in    = nv_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      a_in     = a_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      bsh_in   = bsh_ff;
      root_in  = root_ff;
      quot_in  = quot_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      dist_in  = dist_ff;
      hit_in   = hit_ff;
      le_u_in  = le_u_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      add_x    = '0;
      add_y    = '0;
      add_inv  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action == ACT_LOAD) begin
                  for (int k = 0; k < 3; k++) begin
                     if (req_chan.corner_index == 2'(k)) begin
                        cx_in[k] = req_chan.pos_x;
                        cy_in[k] = req_chan.pos_y;
                        cz_in[k] = req_chan.pos_z;
                     end
                  end
               end else begin
                  d_in[0]  = req_chan.dir_x;
                  d_in[1]  = req_chan.dir_y;
                  d_in[2]  = req_chan.dir_z;
                  w_in[0]  = EW'(req_chan.pos_x) - EW'(cx_ff[0]);
                  w_in[1]  = EW'(req_chan.pos_y) - EW'(cy_ff[0]);
                  w_in[2]  = EW'(req_chan.pos_z) - EW'(cz_ff[0]);
                  e1_in[0] = EW'(cx_ff[1]) - EW'(cx_ff[0]);
                  e1_in[1] = EW'(cy_ff[1]) - EW'(cy_ff[0]);
                  e1_in[2] = EW'(cz_ff[1]) - EW'(cz_ff[0]);
                  e2_in[0] = EW'(cx_ff[2]) - EW'(cx_ff[0]);
                  e2_in[1] = EW'(cy_ff[2]) - EW'(cy_ff[0]);
                  e2_in[2] = EW'(cz_ff[2]) - EW'(cz_ff[0]);
                  op_in    = UOP_FIRST;
                  state_in = ST_START;
               end
            end
         end

         ST_START: begin
            a_in     = a_val;
            bsh_in   = b_val;
            prod_in  = '0;
            cnt_in   = CNT_W'(MB - 1);
            state_in = ST_MUL;
         end

         // MSB-first shift-add; the sign bit of the multiplier subtracts
         ST_MUL: begin
            add_x   = prod_ff << 1;
            add_y   = bsh_ff[MB-1] ? a_ff : '0;
            add_inv = bsh_ff[MB-1] && (cnt_ff == CNT_W'(MB - 1));
            prod_in = add_sum;
            bsh_in  = bsh_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ACC;
            end
         end

         ST_ACC: begin
            add_x   = cur_uop.clr ? '0 : acc_ff;
            add_y   = prod_ff;
            add_inv = cur_uop.neg;
            acc_in  = add_sum;
            case (cur_uop.dest)
               DST_P0:  p_in[0] = add_sum;
               DST_P1:  p_in[1] = add_sum;
               DST_P2:  p_in[2] = add_sum;
               DST_Q0:  q_in[0] = add_sum;
               DST_Q1:  q_in[1] = add_sum;
               DST_Q2:  q_in[2] = add_sum;
               DST_DET: det_in  = add_sum;
               DST_NT:  nt_in   = add_sum;
               DST_NU:  nu_in   = add_sum;
               DST_NV:  nv_in   = add_sum;
               DST_SQ:  dsh_in  = add_sum;
               DST_NTL: rem_in  = add_sum;
               default: acc_in  = add_sum;
            endcase
            if (op_ff == UOP_SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_NORM;
            end else if (op_ff == UOP_LEN) begin
               dsh_in   = det_ff << (N - 1);
               quot_in  = '0;
               cnt_in   = CNT_W'(N - 1);
               state_in = ST_DIVD;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_START;
            end
         end

         // negate nt, nu, nv and finally det when det is negative
         ST_NORM: begin
            add_inv = 1'b1;
            case (cnt_ff[1:0])
               2'd0:    add_y = nt_ff;
               2'd1:    add_y = nu_ff;
               2'd2:    add_y = nv_ff;
               default: add_y = det_ff;
            endcase
            if (det_ff[WW-1]) begin
               case (cnt_ff[1:0])
                  2'd0:    nt_in  = add_sum;
                  2'd1:    nu_in  = add_sum;
                  2'd2:    nv_in  = add_sum;
                  default: det_in = add_sum;
               endcase
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_CMP;
            end
         end

         ST_CMP: begin
            add_x   = det_ff;
            add_y   = (cnt_ff == '0) ? nu_ff : nv_ff;
            add_inv = 1'b1;
            if (cnt_ff == '0) begin
               le_u_in = !add_neg;
               cnt_in  = CNT_W'(1);
            end else begin
               hit_in   = (det_ff != '0) && !nt_ff[WW-1] && !nu_ff[WW-1] &&
                          !nv_ff[WW-1] && le_u_ff && !add_neg;
               rem_in   = nu_ff;
               quot_in  = '0;
               cnt_in   = CNT_W'(F);
               state_in = ST_DIVU;
            end
         end

         // restoring division, one quotient bit per cycle
         ST_DIVU, ST_DIVV: begin
            add_x   = rem_ff;
            add_y   = det_ff;
            add_inv = 1'b1;
            rem_in  = (q_bit ? add_sum : rem_ff) << 1;
            quot_in = {quot_ff[QW-2:0], q_bit};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == ST_DIVU) begin
                  u_in     = {quot_ff[F-1:0], q_bit};
                  rem_in   = nv_ff;
                  quot_in  = '0;
                  cnt_in   = CNT_W'(F);
                  state_in = ST_DIVV;
               end else begin
                  v_in     = {quot_ff[F-1:0], q_bit};
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = CNT_W'(N - 1);
                  state_in = ST_SQRT;
               end
            end
         end

         // two radicand bits per step off the top of dsh
         ST_SQRT: begin
            add_x   = sq_rem;
            add_y   = sq_trial;
            add_inv = 1'b1;
            if (q_bit) begin
               rem_in  = add_sum;
               root_in = {root_ff[N-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem;
               root_in = {root_ff[N-2:0], 1'b0};
            end
            dsh_in = dsh_ff << 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               op_in    = UOP_LEN;
               state_in = ST_START;
            end
         end

         // first step decides saturation, the rest give the quotient
         ST_DIVD: begin
            add_x   = rem_ff;
            add_y   = dsh_ff;
            add_inv = 1'b1;
            if (q_bit) begin
               rem_in = add_sum;
            end
            quot_in = {quot_ff[QW-2:0], q_bit};
            dsh_in  = dsh_ff >> 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               dist_in  = quot_in[N-1] ? '1 : quot_in[N-2:0];
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      d_ff    <= d_in;
      w_ff    <= w_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      det_ff  <= det_in;
      nt_ff   <= nt_in;
      nu_ff   <= nu_in;
      nv_ff   <= nv_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      a_ff    <= a_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      bsh_ff  <= bsh_in;
      root_ff <= root_in;
      quot_ff <= quot_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      dist_ff <= dist_in;
      hit_ff  <= hit_in;
      le_u_ff <= le_u_in;
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = (state_ff == ST_OUT);
   assign rsp_chan.hit      = hit_ff;
   assign rsp_chan.distance = hit_ff ? dist_ff : '0;
   assign rsp_chan.coord_u  = hit_ff ? u_ff : '0;
   assign rsp_chan.coord_v  = hit_ff ? v_ff : '0;

   `ASSERT_IMPLIES(a_one_in_flight, clock, reset, rsp_chan.valid, !req_chan.ready, "request taken while a response is pending")
   `ASSERT_NEXT(a_cast_starts, clock, reset, req_fire && req_chan.action == ACT_CAST, state_ff == ST_START && op_ff == UOP_FIRST, "cast did not start the microprogram")
   `ASSERT_NEXT(a_load_stays_idle, clock, reset, req_fire && req_chan.action == ACT_LOAD, state_ff == ST_IDLE, "corner load left the idle state")
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_chan.valid && !rsp_chan.hit, rsp_chan.distance == '0 && rsp_chan.coord_u == '0 && rsp_chan.coord_v == '0, "miss response carries nonzero fields")
   `ASSERT_IMPLIES(a_uv_range, clock, reset, rsp_chan.valid && rsp_chan.hit, rsp_chan.coord_u <= (F + 1)'(1 << F) && rsp_chan.coord_v <= (F + 1)'(1 << F), "surface coordinate above one")

endmodule
